### rtl/sha_pkg.sv
package sha_pkg;

  localparam int unsigned WordW = 32;

  // round constants
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // initial hash value
  localparam logic [31:0] StartH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  // commands from controller to datapath
  typedef struct packed {
    logic take_byte;    // write input byte at fill position
    logic pad_start;    // write 0x80 at fill position, set pad write pointer just past it
    logic pad_zero;     // write zero at pad pointer, advance
    logic pad_len;      // write length byte at pad pointer, advance
    logic comp_start;   // load working regs and clear round index
    logic comp_round;   // one round
    logic comp_fold;    // add working regs into hash
    logic reset_msg;    // restore initial state
    logic out_shift;    // move to next digest word
  } sha_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       fill_full;  // fill count at the last byte position
    logic       spill;      // no room for the length after the 0x80 marker
    logic [5:0] pad_ptr;
    logic [5:0] round_idx;
  } sha_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

### rtl/sha_ctrl.sv
module sha_ctrl
  import sha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_present_i,
  input  logic      in_end_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output logic [2:0] out_index_o,
  output sha_cmd_t  cmd_o,
  input  sha_stat_t stat_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StComp  = 3'd1;
  localparam logic [2:0] StPad   = 3'd2;
  localparam logic [2:0] StOut   = 3'd3;
  localparam logic [2:0] StFold  = 3'd4;
  localparam logic [2:0] StBeg   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       fin_q, fin_d;     // compression belongs to padding phase
  logic       end_q, end_d;     // end of message pending after compression
  logic       last_q, last_d;   // final padding block
  logic       spill_q, spill_d; // padding block without room for the length
  logic [2:0] idx_q, idx_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_index_o = idx_q;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    end_d   = end_q;
    last_d  = last_q;
    spill_d = spill_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take_byte = in_present_i;
          end_d = in_end_i;
          fin_d = 1'b0;
          if (in_present_i && stat_i.fill_full) begin
            state_d = StBeg;
          end else if (in_end_i) begin
            state_d = StBeg;
            fin_d   = 1'b1;
          end
        end
      end
      StBeg: begin
        if (fin_q && end_q) begin
          cmd_o.pad_start = 1'b1;
          end_d   = 1'b0;
          spill_d = stat_i.spill;
          // marker in the last byte completes the block at once
          if (stat_i.fill_full) begin
            state_d = StBeg;
          end else begin
            state_d = StPad;
          end
        end else begin
          cmd_o.comp_start = 1'b1;
          state_d = StComp;
        end
      end
      StPad: begin
        // length bytes only in the final block
        if (stat_i.pad_ptr >= LenPos && !spill_q) begin
          cmd_o.pad_len = 1'b1;
        end else begin
          cmd_o.pad_zero = 1'b1;
        end
        if (stat_i.pad_ptr == 6'd63) begin
          last_d  = !spill_q;
          state_d = StBeg;
        end
      end
      StComp: begin
        cmd_o.comp_round = 1'b1;
        if (stat_i.round_idx == 6'd63) begin
          state_d = StFold;
        end
      end
      StFold: begin
        cmd_o.comp_fold = 1'b1;
        if (!fin_q && end_q) begin
          fin_d   = 1'b1;
          state_d = StBeg;
        end else if (!fin_q) begin
          state_d = StIdle;
        end else if (last_q) begin
          idx_d   = 3'd0;
          state_d = StOut;
        end else begin
          // spill block done, pad the length block
          spill_d = 1'b0;
          state_d = StPad;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.out_shift = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.reset_msg = 1'b1;
            last_d  = 1'b0;
            fin_d   = 1'b0;
            spill_d = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
      end_q   <= 1'b0;
      last_q  <= 1'b0;
      spill_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      end_q   <= end_d;
      last_q  <= last_d;
      spill_q <= spill_d;
      idx_q   <= idx_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("output while accepting input");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && idx_q == 3'd7) |=> in_ready_o)
    else $error("no return to idle after digest");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.comp_round, cmd_o.take_byte, cmd_o.pad_zero, cmd_o.pad_len}))
    else $error("conflicting datapath commands");

endmodule

### rtl/sha_dp.sv
module sha_dp
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  sha_cmd_t    cmd_i,
  input  logic [2:0]  out_index_i,
  output logic [31:0] digest_word_o,
  output sha_stat_t   stat_o
);

  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [5:0]  pad_q;
  logic [5:0]  rnd_q;
  logic [31:0] h_q [8];
  logic [31:0] r_q [8];
  logic [31:0] w_q [16];
  logic [63:0] total;
  logic [31:0] t1, t2, s0, s1, wnew, wcur;
  logic [7:0]  len_byte;

  // length bytes sit at 56..63, most significant first
  assign total = bits_q + {55'd0, fill_q, 3'd0};
  assign len_byte = total[{~pad_q[2:0], 3'b000} +: 8];
  assign stat_o.fill_full = (fill_q == 6'd63);
  assign stat_o.spill     = (fill_q >= LenPos);
  assign stat_o.pad_ptr   = pad_q;
  assign stat_o.round_idx = rnd_q;
  assign digest_word_o    = h_q[out_index_i];

  // round function and schedule extension
  assign wcur = w_q[0];
  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;
  assign t1 = r_q[7] + (rotr(r_q[4], 6) ^ rotr(r_q[4], 11) ^ rotr(r_q[4], 25)) +
              ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6])) + RoundK[rnd_q] + wcur;
  assign t2 = (rotr(r_q[0], 2) ^ rotr(r_q[0], 13) ^ rotr(r_q[0], 22)) +
              ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));

  // block bytes, padding included, held big-endian in the schedule words
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= data_byte_i;
    if (cmd_i.pad_start) w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= PadByte;
    if (cmd_i.pad_zero)  w_q[pad_q[5:2]][{~pad_q[1:0], 3'b000} +: 8]   <= 8'd0;
    if (cmd_i.pad_len)   w_q[pad_q[5:2]][{~pad_q[1:0], 3'b000} +: 8]   <= len_byte;
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
    end
    if (cmd_i.comp_round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      r_q[7] <= r_q[6]; r_q[6] <= r_q[5]; r_q[5] <= r_q[4]; r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2]; r_q[2] <= r_q[1]; r_q[1] <= r_q[0]; r_q[0] <= t1 + t2;
    end
  end

  // counters and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bits_q <= '0;
      pad_q  <= '0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= StartH[i];
    end else begin
      if (cmd_i.take_byte) begin
        fill_q <= fill_q + 6'd1;
        if (fill_q == 6'd63) bits_q <= bits_q + 64'd512;
      end
      if (cmd_i.pad_start) pad_q <= fill_q + 6'd1;
      if (cmd_i.pad_zero || cmd_i.pad_len) pad_q <= pad_q + 6'd1;
      if (cmd_i.comp_start) rnd_q <= '0;
      if (cmd_i.comp_round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.comp_fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
      end
      if (cmd_i.reset_msg) begin
        fill_q <= '0;
        bits_q <= '0;
        pad_q  <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= StartH[i];
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.comp_round |-> !cmd_i.take_byte) else $error("byte written during rounds");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reset_msg |=> (fill_q == 6'd0 && bits_q == 64'd0))
    else $error("message state not cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.comp_round && rnd_q == 6'd63) |=> cmd_i.comp_fold)
    else $error("fold missing after last round");

endmodule

### rtl/sha256_byte_stream_hasher.sv
// channel | dir | tdata (low bit first)                        | tuser
// s_axis  | in  | data_byte[7:0]                               | byte_present
//         |     |                                              | tlast = end_of_message
// m_axis  | out | digest_word[31:0]                            | word_index[2:0]
//         |     |                                              | tlast = last_word
// bytes are taken only while idle; a byte that fills the block starts a
// compression (64 rounds of the single round unit plus load and fold)
// an end item pads byte-wise and compresses once or twice, then offers
// eight digest words; each waits on m_axis_tready
// asynchronous active-low reset restores the initial hash value
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast
);

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic [2:0] idx;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_present_i(s_axis_tuser),
    .in_end_i(s_axis_tlast), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_index_o(idx), .cmd_o(cmd), .stat_i(stat)
  );

  sha_dp u_dp (
    .clk_i, .rst_ni,
    .data_byte_i(s_axis_tdata), .cmd_i(cmd), .out_index_i(idx),
    .digest_word_o(m_axis_tdata), .stat_o(stat)
  );

  assign m_axis_tuser = idx;
  assign m_axis_tlast = (idx == 3'd7);

endmodule
